/* sv/canonical_decimal_u64_parser_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef CANONICAL_DECIMAL_U64_PARSER_ASSERT_SVH
`define CANONICAL_DECIMAL_U64_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while rst_n is low.
`define CDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDP_ASSERT(lbl, prop, msg)
`define CDP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/cdp_pkg.sv */
`default_nettype none
package cdp_pkg;

  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 5;
  localparam int VAL_W   = 64;
  localparam int MAX_LEN = 20;
  localparam int OUT_W   = 72;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NONCANON = 2'd1,
    STATUS_RANGE    = 2'd2
  } cdp_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty_string;
  } cdp_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             lz_seen;
    logic             nd_found;
    logic [CNT_W-1:0] nd_off;
    logic             ov_found;
    logic [CNT_W-1:0] ov_off;
  } cdp_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] parsed_value;
    logic             offset_valid;
    logic [CNT_W-1:0] error_offset;
    cdp_status_t      status;
  } cdp_result_t;

endpackage
`default_nettype wire

/* sv/cdp_in_reg.sv */
`default_nettype none
module cdp_in_reg
  import cdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [CHAR_W-1:0] in_tdata,   // [7:0] character
  input  wire logic              in_tlast,
  input  wire logic              in_tuser,   // [0] empty_string
  input  wire logic              advance,
  output logic                   item_valid,
  output cdp_item_t              item
);

  logic      valid_r, valid_nxt;
  cdp_item_t item_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.character    <= in_tdata;
      item_r.last         <= in_tlast;
      item_r.empty_string <= in_tuser;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* sv/cdp_parse_core.sv */
`default_nettype none
module cdp_parse_core
  import cdp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire cdp_item_t item,
  output cdp_result_t    result
);

`include "canonical_decimal_u64_parser_assert.svh"

  localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);

  cdp_state_t        st_r, st_nxt, ns;
  logic              take, inspect, is_digit;
  logic [3:0]        digit;
  logic [VAL_W+3:0]  prod;
  logic              ovf;

  // acc*10 + d; any bit from 64 up means overflow
  always_comb begin
    take     = !item.empty_string;
    inspect  = take && (st_r.cnt < MAX_LEN_C);
    is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
    digit    = 4'(item.character - CHAR_ZERO);
    prod     = {1'b0, st_r.acc, 3'b000} + {3'b000, st_r.acc, 1'b0}
             + {(VAL_W)'(0), digit};
    ovf      = |prod[VAL_W+3:VAL_W];
  end

  always_comb begin
    ns = st_r;
    if (inspect && (st_r.cnt == '0) && (item.character == CHAR_ZERO)) begin
      ns.lz_seen = 1'b1;
    end
    if (inspect && !is_digit && !st_r.nd_found) begin
      ns.nd_found = 1'b1;
      ns.nd_off   = st_r.cnt;
    end
    if (inspect && is_digit && !st_r.ov_found) begin
      if (ovf) begin
        ns.ov_found = 1'b1;
        ns.ov_off   = st_r.cnt;
      end else begin
        ns.acc = prod[VAL_W-1:0];
      end
    end
    if (take && (st_r.cnt <= MAX_LEN_C)) begin
      ns.cnt = st_r.cnt + ONE_C;
    end
  end

  always_comb begin
    result.parsed_value = '0;
    result.offset_valid = 1'b1;
    result.error_offset = '0;
    result.status       = STATUS_OK;
    if (ns.cnt == '0) begin
      result.status = STATUS_NONCANON;
    end else if (ns.cnt > MAX_LEN_C) begin
      result.status       = STATUS_RANGE;
      result.error_offset = MAX_LEN_C;
    end else if (ns.lz_seen && (ns.cnt != ONE_C)) begin
      result.status       = STATUS_NONCANON;
      result.error_offset = ONE_C;
    end else if (ns.nd_found) begin
      result.status       = STATUS_NONCANON;
      result.error_offset = ns.nd_off;
    end else if (ns.ov_found) begin
      result.status       = STATUS_RANGE;
      result.error_offset = ns.ov_off;
    end else begin
      result.offset_valid = 1'b0;
      result.parsed_value = ns.acc;
    end
  end

  // string closes -> back to the cleared state
  always_comb begin
    st_nxt = st_r;
    if (fire) begin
      st_nxt = item.last ? '0 : ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  `CDP_ASSERT(a_cnt_bound, (st_r.cnt <= MAX_LEN_C + ONE_C), "char count past saturation")
  `CDP_ASSERT(a_clear_after_last, (fire && item.last |=> (st_r == '0)), "state not cleared")
  `CDP_ASSERT(a_off_bound, (st_r.nd_off < MAX_LEN_C && st_r.ov_off < MAX_LEN_C), "offset range")

endmodule
`default_nettype wire

/* sv/cdp_out_reg.sv */
`default_nettype none
module cdp_out_reg
  import cdp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cdp_result_t      result,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata  // status, error_offset, offset_valid, parsed_value
);

  logic        valid_r, valid_nxt;
  cdp_result_t data_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_W'(data_r);

endmodule
`default_nettype wire

/* sv/canonical_decimal_u64_parser.sv */
`default_nettype none
// A closing item waits in the input register until the output register can load.
// Throughput: one character item per cycle, except that a closing item stalls while
// the output register is full; the multiply-by-ten/add step is combinational.
// Reset: rst_n synchronous, active low; clears the parse state and both valid flags.
module canonical_decimal_u64_parser
  import cdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [CHAR_W-1:0] in_tdata,   // [7:0] character
  input  wire logic              in_tlast,
  input  wire logic              in_tuser,   // [0] empty_string
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata   // [1:0] status, [6:2] error_offset,
                                             // [7] offset_valid, [71:8] parsed_value
);

`include "canonical_decimal_u64_parser_assert.svh"

  logic        item_valid, advance, can_load;
  cdp_item_t   item;
  cdp_result_t result;

  assign advance = item_valid && (!item.last || can_load);

  cdp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cdp_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  cdp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && item.last),
    .result     (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `CDP_ASSERT(a_result_follows, (advance && item.last |=> out_tvalid), "result missing")
  `CDP_ASSERT(a_fail_fields,
              (out_tvalid && out_tdata[1:0] != STATUS_OK |->
               out_tdata[7] && out_tdata[71:8] == '0), "failure fields")
  `CDP_ASSERT(a_ok_fields,
              (out_tvalid && out_tdata[1:0] == STATUS_OK |->
               !out_tdata[7] && out_tdata[6:2] == '0), "ok fields")
  `CDP_ASSERT_ALWAYS(a_reset_idle, (!$past(rst_n) |-> !out_tvalid), "valid after reset")

endmodule
`default_nettype wire

/* tb/sv/cdp_parse_checker.sv */
module cdp_parse_checker
  import cdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] character
  input  logic              in_tlast,
  input  logic              in_tuser,   // [0] empty_string
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,  // [1:0] status, [6:2] error_offset,
                                        // [7] offset_valid, [71:8] parsed_value
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                ok_seen
);

  logic [VAL_W-1:0] acc;
  logic [CNT_W-1:0] len;
  logic             zero_first;
  logic             bad_char;
  logic [CNT_W-1:0] bad_pos;
  logic             ovf;
  logic [CNT_W-1:0] ovf_pos;

  cdp_result_t parse_results_due[$];
  int          fails;
  int          n_checked;
  int          n_ok;

  function automatic void clear_parse();
    acc        = '0;
    len        = '0;
    zero_first = 1'b0;
    bad_char   = 1'b0;
    bad_pos    = '0;
    ovf        = 1'b0;
    ovf_pos    = '0;
  endfunction

  function automatic void fold_char(input logic [CHAR_W-1:0] ch);
    logic [VAL_W+3:0] wide;
    logic [CHAR_W-1:0] dig;
    if (len < MAX_LEN) begin
      if (len == 0 && ch == CHAR_ZERO) zero_first = 1'b1;
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
        if (!bad_char) begin
          bad_char = 1'b1;
          bad_pos  = len;
        end
      end else if (!ovf) begin
        dig  = ch - CHAR_ZERO;
        wide = {4'b0, acc} * (VAL_W+4)'(10) + (VAL_W+4)'(dig);
        // anything past 2^64-1 marks the overflow position
        if (wide[VAL_W+3:VAL_W] != 4'b0) begin
          ovf     = 1'b1;
          ovf_pos = len;
        end else begin
          acc = wide[VAL_W-1:0];
        end
      end
    end
    if (len <= MAX_LEN) len = len + 1'b1;
  endfunction

  function automatic cdp_result_t finish_string();
    cdp_result_t r;
    r.parsed_value = '0;
    r.offset_valid = 1'b1;
    r.error_offset = '0;
    r.status       = STATUS_NONCANON;
    if (len == 0) begin
      r.status = STATUS_NONCANON;
    end else if (len > MAX_LEN) begin
      r.status       = STATUS_RANGE;
      r.error_offset = CNT_W'(MAX_LEN);
    end else if (zero_first && len != 1) begin
      r.error_offset = CNT_W'(1);
    end else if (bad_char) begin
      r.error_offset = bad_pos;
    end else if (ovf) begin
      r.status       = STATUS_RANGE;
      r.error_offset = ovf_pos;
    end else begin
      r.status       = STATUS_OK;
      r.offset_valid = 1'b0;
      r.parsed_value = acc;
    end
    return r;
  endfunction

  task automatic check_result(input logic [OUT_W-1:0] got);
    cdp_result_t want;
    if (parse_results_due.size() == 0) begin
      $display("%0t: unexpected result, got %h", $time, got);
      fails++;
    end else begin
      want = parse_results_due.pop_front();
      n_checked++;
      if (want.status == STATUS_OK) n_ok++;
      if (got[1:0] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got[1:0]);
        fails++;
      end
      if (got[6:2] !== want.error_offset) begin
        $display("%0t: error_offset expected %0d actual %0d", $time, want.error_offset,
                 got[6:2]);
        fails++;
      end
      if (got[7] !== want.offset_valid) begin
        $display("%0t: offset_valid expected %0b actual %0b", $time, want.offset_valid,
                 got[7]);
        fails++;
      end
      if (got[71:8] !== want.parsed_value) begin
        $display("%0t: parsed_value expected %0d actual %0d", $time, want.parsed_value,
                 got[71:8]);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      parse_results_due.delete();
      fails     = 0;
      n_checked = 0;
      n_ok      = 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        if (!in_tuser) fold_char(in_tdata);
        if (in_tlast) begin
          parse_results_due.push_back(finish_string());
          clear_parse();
        end
      end
    end
    fail_count   <= fails;
    pending      <= parse_results_due.size();
    results_seen <= n_checked;
    ok_seen      <= n_ok;
  end

endmodule

/* tb/sv/tb_canonical_decimal_u64_parser.sv */
module tb_canonical_decimal_u64_parser;
  import cdp_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;   // [7:0] character
  logic              in_tlast;
  logic              in_tuser;   // [0] empty_string
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // [1:0] status, [6:2] error_offset,
                                 // [7] offset_valid, [71:8] parsed_value

  int fail_count;
  int pending;
  int results_seen;
  int ok_seen;

  bit calm;
  bit holey;
  bit hold_req;
  bit hold_started;
  int items_sent;
  int strings_sent;

  cdp_item_t text_q[$];

  canonical_decimal_u64_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cdp_parse_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .ok_seen      (ok_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random back-pressure plus one long hold
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  function automatic cdp_item_t mk_item(input logic [7:0] ch, input logic lst,
                                        input logic emp);
    cdp_item_t it;
    it.character    = ch;
    it.last         = lst;
    it.empty_string = emp;
    return it;
  endfunction

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c >= CHAR_ZERO && c <= CHAR_NINE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_digit(input int lo);
    logic [7:0] c;
    c = CHAR_ZERO + 8'($urandom_range(lo, 9));
    return c;
  endfunction

  function automatic logic [63:0] rand_u64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(0, 63);
  endfunction

  task automatic add_char(input logic [7:0] ch);
    if (holey && $urandom_range(99) < 10)
      text_q.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    text_q.push_back(mk_item(ch, 1'b0, 1'b0));
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_char(s[i]);
  endtask

  task automatic add_number(input logic [63:0] v);
    logic [7:0] digs[$];
    logic [63:0] r;
    logic [7:0] d;
    r = v;
    do begin
      d = 8'(r % 10);
      digs.push_front(CHAR_ZERO + d);
      r = r / 10;
    end while (r != 0);
    foreach (digs[i]) add_char(digs[i]);
  endtask

  task automatic push_item(input cdp_item_t it);
    while (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      in_tlast  <= 1'($urandom_range(0, 1));
      in_tuser  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.character;
    in_tlast  <= it.last;
    in_tuser  <= it.empty_string;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // close the string, either on its final char or with a char-less closing item
  task automatic send_string(input bit separate_close);
    cdp_item_t it;
    if (separate_close || text_q.size() == 0) begin
      text_q.push_back(mk_item(8'($urandom_range(0, 255)), 1'b1, 1'b1));
    end else begin
      it = text_q.pop_back();
      it.last = 1'b1;
      text_q.push_back(it);
    end
    while (text_q.size() > 0) push_item(text_q.pop_front());
    strings_sent++;
    holey = 1'b0;
  endtask

  task automatic build_random_string(output bit separate_close);
    int kind;
    int n;
    int k;
    logic [63:0] p;
    logic [7:0] c;
    kind  = $urandom_range(99);
    holey = ($urandom_range(99) < 8);
    separate_close = ($urandom_range(99) < 12);
    if (kind < 45) begin
      add_number(rand_u64());
    end else if (kind < 55) begin
      holey = 1'b0;
      case ($urandom_range(4))
        0: add_number(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 30));
        1: begin
          add_number(64'hFFFF_FFFF_FFFF_FFFF);
          k = $urandom_range(0, 19);
          c = text_q[k].character;
          if (c < CHAR_NINE)
            text_q[k] = mk_item(c + 8'($urandom_range(1, CHAR_NINE - c)), 1'b0, 1'b0);
        end
        2: begin
          add_char(rand_digit(2));
          repeat (19) add_char(rand_digit(0));
        end
        default: begin
          p = 1;
          repeat ($urandom_range(0, 19)) p = p * 10;
          add_number($urandom_range(0, 1) ? p : p - 1);
        end
      endcase
    end else if (kind < 63) begin
      n = $urandom_range(21, 24);
      add_char(rand_digit(1));
      repeat (n - 1) add_char($urandom_range(99) < 90 ? rand_digit(0) : rand_nondigit());
    end else if (kind < 71) begin
      add_char(CHAR_ZERO);
      repeat ($urandom_range(1, 4))
        add_char($urandom_range(99) < 80 ? rand_digit(0) : rand_nondigit());
    end else if (kind < 83) begin
      add_number(rand_u64());
      k = $urandom_range(0, text_q.size());
      text_q.insert(k, mk_item(rand_nondigit(), 1'b0, 1'b0));
    end else if (kind < 89) begin
      separate_close = 1'b1;
      repeat ($urandom_range(0, 2))
        text_q.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end else begin
      n = $urandom_range(1, 22);
      repeat (n)
        add_char($urandom_range(99) < 50 ? rand_digit(0) : 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit sep;
    int rnd_strings;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = 1'b0;
    calm       = 1'b0;
    holey      = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    strings_sent = 0;
    rnd_strings  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty string, single digits, leading zero, edge non-digits
    text_q.push_back(mk_item(8'hFF, 1'b1, 1'b1));
    send_string(1'b0);
    add_text("0");
    send_string(1'b0);
    add_text("9");
    send_string(1'b0);
    add_text("05");
    send_string(1'b0);
    add_text("/");
    send_string(1'b0);
    add_text(":");
    send_string(1'b0);
    add_text("0x");
    send_string(1'b0);
    add_text("a0");
    send_string(1'b0);
    // char-less item mid-string, then char-less close
    add_text("1");
    text_q.push_back(mk_item(8'h00, 1'b0, 1'b1));
    add_text("2");
    send_string(1'b1);

    while (items_sent < ITEM_TARGET) begin
      calm = (rnd_strings >= 20 && rnd_strings < 45);
      if (rnd_strings == 60) hold_req = 1'b1;
      build_random_string(sep);
      send_string(sep);
      rnd_strings++;
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items in %0d strings; checked %0d results, %0d of them ok.",
             items_sent, strings_sent, results_seen, ok_seen);
    $display("Covered 64-bit limits, overflow, overlong, leading-zero, non-digit and empty.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/cdp_pkg.sv
sv/cdp_in_reg.sv
sv/cdp_parse_core.sv
sv/cdp_out_reg.sv
sv/canonical_decimal_u64_parser.sv
tb/sv/cdp_parse_checker.sv
tb/sv/tb_canonical_decimal_u64_parser.sv
